### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, muted while reset is high.
`define ASSERT_CLKD(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check sampled on the rising clock, live during reset too.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/hpt_pkg.sv
`timescale 1ns / 1ps
package hpt_pkg;

  localparam int DEF_COORD_WIDTH = 24;
  localparam int DEF_FRAC_BITS   = 12;
  localparam int COEF_WIDTH      = 16;
  localparam int COEF_FRAC       = 12;
  localparam int CFG_WIDTH       = 32;
  localparam int CFG_IDX_WIDTH   = 3;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0_COL01 = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0_COL23 = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1_COL01 = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1_COL23 = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2_COL01 = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2_COL23 = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW3_COL01 = 3'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW3_COL23 = 3'd7;

  // Control that travels with one request down the divider cells.
  typedef struct packed {
    logic       valid;
    logic       dz;
    logic [2:0] ovf;
    logic [2:0] neg;
  } hpt_ctl_t;

endpackage

### hw/rtl/hpt_front.sv
`timescale 1ns / 1ps
module hpt_front import hpt_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS,
  parameter int EW          = 2 * DEF_COORD_WIDTH + 19
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_vec,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic signed [COEF_WIDTH-1:0]  coef [4][4],
  input  logic                          en_down,
  output logic                          en_up,
  output hpt_ctl_t                      ctl,
  output logic        [EW-1:0]          rem [3],
  output logic        [EW-1:0]          dvs
);

  localparam int PW = COORD_WIDTH + COEF_WIDTH;
  localparam int AW = COORD_WIDTH + 18;
  localparam logic [AW-1:0] WOne = {{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC + FRAC_BITS);

  logic                          va, vb;
  logic                          vec_a, vec_b;
  logic                          en_a, en_b, en_c;
  logic signed [PW-1:0]          prod_a [4][3];
  logic signed [COEF_WIDTH-1:0]  tr_a [4];
  logic signed [AW-1:0]          acc_b [4];
  logic signed [COORD_WIDTH-1:0] crd [3];
  logic signed [AW-1:0]          w;
  logic        [AW-1:0]          den;
  logic        [AW-1:0]          nmag [3];
  logic                          direct;
  hpt_ctl_t                      ctl_next;
  logic        [EW-1:0]          rem_next [3];

  assign crd[0] = in_x;
  assign crd[1] = in_y;
  assign crd[2] = in_z;

  assign en_c  = ~ctl.valid | en_down;
  assign en_b  = ~vb | en_c;
  assign en_a  = ~va | en_b;
  assign en_up = en_a;

  // Products stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      vec_a <= in_vec;
      for (int r = 0; r < 4; r++) begin
        tr_a[r] <= coef[r][3];
        for (int c = 0; c < 3; c++) begin
          prod_a[r][c] <= PW'(coef[r][c]) * PW'(crd[c]);
        end
      end
    end
  end

  // Row sums; rows 0..2 drop translation for direction vectors.
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      vec_b <= vec_a;
      for (int r = 0; r < 4; r++) begin
        acc_b[r] <= AW'(prod_a[r][0]) + AW'(prod_a[r][1]) + AW'(prod_a[r][2])
                  + (((r == 3) || !vec_a) ? (AW'(tr_a[r]) <<< FRAC_BITS) : AW'(0));
      end
    end
  end

  // Divisor selection and overflow check; a plain rescale divides by one.
  always_comb begin
    w      = acc_b[3];
    direct = vec_b || (w == WOne);
    den    = direct ? WOne : (w[AW-1] ? AW'(-w) : AW'(w));
    ctl_next.valid = vb;
    ctl_next.dz    = !vec_b && (w == '0);
    for (int k = 0; k < 3; k++) begin
      nmag[k]        = acc_b[k][AW-1] ? AW'(-acc_b[k]) : AW'(acc_b[k]);
      rem_next[k]    = EW'(nmag[k]) << FRAC_BITS;
      ctl_next.ovf[k] = rem_next[k] >= (EW'(den) << COORD_WIDTH);
      ctl_next.neg[k] = acc_b[k][AW-1] ^ (!direct & w[AW-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en_c) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      rem <= rem_next;
      dvs <= EW'(den) << (COORD_WIDTH - 1);
    end
  end

endmodule

### hw/rtl/hpt_div_cell.sv
`timescale 1ns / 1ps
module hpt_div_cell import hpt_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int EW          = 2 * DEF_COORD_WIDTH + 19
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hpt_ctl_t               ctl_in,
  input  logic [EW-1:0]          rem_in [3],
  input  logic [EW-1:0]          dvs_in,
  input  logic [COORD_WIDTH-1:0] q_in [3],
  input  logic                   en_down,
  output logic                   en_up,
  output hpt_ctl_t               ctl,
  output logic [EW-1:0]          rem [3],
  output logic [EW-1:0]          dvs,
  output logic [COORD_WIDTH-1:0] q [3]
);

  logic ge [3];

  assign en_up = ~ctl.valid | en_down;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ge[k] = rem_in[k] >= dvs_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en_up) begin
      ctl <= ctl_in;
    end
  end

  // One restoring step per lane: subtract where it fits, shift in the bit.
  always_ff @(posedge clk) begin
    if (en_up) begin
      dvs <= dvs_in >> 1;
      for (int k = 0; k < 3; k++) begin
        rem[k] <= ge[k] ? (rem_in[k] - dvs_in) : rem_in[k];
        q[k]   <= {q_in[k][COORD_WIDTH-2:0], ge[k]};
      end
    end
  end

endmodule

### hw/rtl/hpt_out.sv
`timescale 1ns / 1ps
module hpt_out import hpt_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int OW          = ((3 * DEF_COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hpt_ctl_t               ctl_in,
  input  logic [COORD_WIDTH-1:0] q_in [3],
  output logic                   en_up,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OW-1:0]          m_tdata,
  output logic [1:0]             m_tuser
);

  localparam logic [COORD_WIDTH-1:0] MaxPos = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MaxNeg = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [COORD_WIDTH-1:0] mag [3];
  logic [COORD_WIDTH-1:0] val [3];
  logic                   clip [3];
  logic                   sat_any;

  assign en_up = ~m_tvalid | m_tready;

  always_comb begin
    sat_any = 1'b0;
    for (int k = 0; k < 3; k++) begin
      clip[k] = ctl_in.ovf[k] | (ctl_in.neg[k] ? (q_in[k] > MaxNeg) : (q_in[k] > MaxPos));
      mag[k]  = clip[k] ? (ctl_in.neg[k] ? MaxNeg : MaxPos) : q_in[k];
      val[k]  = ctl_in.dz ? '0 : (ctl_in.neg[k] ? -mag[k] : mag[k]);
      sat_any = sat_any | clip[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_up) begin
      m_tvalid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_up) begin
      m_tdata <= OW'({val[2], val[1], val[0]});
      m_tuser <= {sat_any & ~ctl_in.dz, ctl_in.dz};
    end
  end

endmodule

### hw/rtl/homogeneous_point_transform.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while m_tready holds; every stage and divider cell is registered.
// The divide runs as a chain of COORD_WIDTH restoring-divider cells, one bit each.
// Reset (rst, synchronous, active high) empties the pipeline and loads identity.
`include "assert_macros.svh"
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                                         clk,
  input  logic                                         rst,
  // Input requests.
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // in_x, in_y, in_z
  input  logic                                         s_tuser,  // opcode
  // Results.
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  output logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,  // out_x, out_y, out_z
  output logic [1:0]                                   m_tuser,  // divide_by_zero, saturated
  // Matrix register writes.
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]                     cfg_index,
  input  logic [CFG_WIDTH-1:0]                         cfg_data
);

  localparam int EW = 2 * COORD_WIDTH + 19;
  localparam int DW = ((3 * COORD_WIDTH + 7) / 8) * 8;

  // Matrix registers: each holds two Q4.12 coefficients, first column low.
  logic [CFG_WIDTH-1:0] row0_col01, row0_col23, row1_col01, row1_col23;
  logic [CFG_WIDTH-1:0] row2_col01, row2_col23, row3_col01, row3_col23;
  logic signed [COEF_WIDTH-1:0] coef [4][4];

  // Stage 0 is the front end output; stage i+1 is divider cell i output.
  hpt_ctl_t               ctl_s [COORD_WIDTH+1];
  logic [EW-1:0]          rem_s [COORD_WIDTH+1][3];
  logic [EW-1:0]          dvs_s [COORD_WIDTH+1];
  logic [COORD_WIDTH-1:0] q_s   [COORD_WIDTH+1][3];
  logic                   en_s  [COORD_WIDTH+1];

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_col01 <= 32'h0000_1000;
      row0_col23 <= 32'h0000_0000;
      row1_col01 <= 32'h1000_0000;
      row1_col23 <= 32'h0000_0000;
      row2_col01 <= 32'h0000_0000;
      row2_col23 <= 32'h0000_1000;
      row3_col01 <= 32'h0000_0000;
      row3_col23 <= 32'h1000_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0_COL01: row0_col01 <= cfg_data;
        REG_ROW0_COL23: row0_col23 <= cfg_data;
        REG_ROW1_COL01: row1_col01 <= cfg_data;
        REG_ROW1_COL23: row1_col23 <= cfg_data;
        REG_ROW2_COL01: row2_col01 <= cfg_data;
        REG_ROW2_COL23: row2_col23 <= cfg_data;
        REG_ROW3_COL01: row3_col01 <= cfg_data;
        REG_ROW3_COL23: row3_col23 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Split the registers into the coefficient grid; column 3 is translation.
  always_comb begin
    coef[0][0] = row0_col01[15:0];  coef[0][1] = row0_col01[31:16];
    coef[0][2] = row0_col23[15:0];  coef[0][3] = row0_col23[31:16];
    coef[1][0] = row1_col01[15:0];  coef[1][1] = row1_col01[31:16];
    coef[1][2] = row1_col23[15:0];  coef[1][3] = row1_col23[31:16];
    coef[2][0] = row2_col01[15:0];  coef[2][1] = row2_col01[31:16];
    coef[2][2] = row2_col23[15:0];  coef[2][3] = row2_col23[31:16];
    coef[3][0] = row3_col01[15:0];  coef[3][1] = row3_col01[31:16];
    coef[3][2] = row3_col23[15:0];  coef[3][3] = row3_col23[31:16];
  end

  // Multiply, sum the rows and pick the divisor. Direction vectors and a w of
  // exactly one divide by 2^(12+FRAC_BITS), which is the plain rescale.
  hpt_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .EW          (EW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_vec   (s_tuser),
    .in_x     (s_tdata[COORD_WIDTH-1:0]),
    .in_y     (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_z     (s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
    .coef     (coef),
    .en_down  (en_s[0]),
    .en_up    (s_tready),
    .ctl      (ctl_s[0]),
    .rem      (rem_s[0]),
    .dvs      (dvs_s[0])
  );

  // Quotients start empty; each cell shifts in one bit, MSB first.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_s[0][k] = '0;
    end
  end

  for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_cell
    hpt_div_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .EW          (EW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[i]),
      .rem_in  (rem_s[i]),
      .dvs_in  (dvs_s[i]),
      .q_in    (q_s[i]),
      .en_down (en_s[i+1]),
      .en_up   (en_s[i]),
      .ctl     (ctl_s[i+1]),
      .rem     (rem_s[i+1]),
      .dvs     (dvs_s[i+1]),
      .q       (q_s[i+1])
    );
  end

  // Apply sign, clamp and hold the result until it is taken.
  hpt_out #(
    .COORD_WIDTH (COORD_WIDTH),
    .OW          (DW)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl_s[COORD_WIDTH]),
    .q_in     (q_s[COORD_WIDTH]),
    .en_up    (en_s[COORD_WIDTH]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A zero divisor yields zero coordinates and never flags a clamp.
  `ASSERT_CLKD(a_dz_zero, clk, rst, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]), "divide by zero result not cleared")
  // With the output register empty no stage can be blocked.
  `ASSERT_CLKD(a_ready_free, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")
  // A write to the first register lands on the next edge.
  `ASSERT_CLKD(a_cfg_write, clk, rst, (cfg_valid && cfg_index == REG_ROW0_COL01) |=> (row0_col01 == $past(cfg_data)), "register write lost")

endmodule
